[rtl/rfr_pkg.sv]
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared types and constants of the reader reply frame receiver.
// ----------------------------------------------------------------------------
package rfr_pkg;

   localparam int BUFFER_BYTES = 64;
   localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);
   localparam int RECV_W       = 7;
   localparam int LEN_W        = 16;
   localparam int CKPOS_W      = LEN_W + 1;
   localparam int TICK_W       = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   // request codes
   localparam logic [1:0] REQ_BYTE = 2'd0;
   localparam logic [1:0] REQ_TICK = 2'd1;
   localparam logic [1:0] REQ_ARM  = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_END      = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_BYTE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_BYTE      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 2'd2;

   localparam logic [7:0]        HEADER_BYTE_RESET = 8'hAA;
   localparam logic [7:0]        END_BYTE_RESET    = 8'hDD;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET     = 16'd1000;
   localparam logic [TICK_W-1:0] TICK_MAX          = 16'hFFFF;
   localparam logic [CKPOS_W-1:0] CKPOS_OFFSET     = 17'd5;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              frame_ok;
      logic              checksum_ok;
      logic [7:0]        command_code;
      logic [7:0]        frame_kind;
      logic [LEN_W-1:0]  param_length;
      logic [RECV_W-1:0] bytes_received;
   } rsp_word_type;

endpackage

[rtl/rfid_frame_receiver_checker_core.sv]
// ----------------------------------------------------------------------------
// rfid_frame_receiver_checker_core
// Frame receiver with header, length, sum checksum and end byte checks.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one word per event: a received byte, a time tick or an arm
//            request that opens a new reception (an open one is dropped).
//   rsp_*  : one status word per closed frame: closed by end byte, timeout
//            or buffer overflow, with framing and checksum flags.
//   csr_*  : register writes (header byte, end byte, timeout ticks); always
//            ready, to be used while the block is idle.
// Latency: if not stalled, a closing word shows on rsp_valid the cycle after.
// Throughput: one word per cycle unless req_stall; each word is handled by a
//   single state update between the frame registers and the output register.
// A two-deep output (output register plus skid register) keeps req_stall low
//   while one result waits; req_stall rises only when the skid register holds
//   a second result under a stalled receiver.
// Reset: synchronous, clears the frame state and output valids and restores
//   the register defaults; no reception is open until an arm request.
// ----------------------------------------------------------------------------
module rfid_frame_receiver_checker_core
   import rfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [7:0]         header_byte_ff;
   logic [7:0]         end_byte_ff;
   logic [TICK_W-1:0]  timeout_ff;

   logic               active_ff, active_in;
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [TICK_W-1:0]  tick_count_ff, tick_count_in;
   logic               header_matched_ff, header_matched_in;
   logic [7:0]         kind_ff, kind_in;
   logic [7:0]         command_ff, command_in;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         checksum_ff, checksum_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;
   logic               skid_valid_ff, skid_valid_in;
   rsp_word_type       skid_word_ff, skid_word_in;

   logic               accept;
   logic               produce;
   logic [1:0]         status;
   rsp_word_type       result;
   logic [7:0]         rx;
   logic [LEN_W-1:0]   length_upd;
   logic [CKPOS_W-1:0] ckpos_upd;
   logic [CKPOS_W-1:0] pos_wide;
   logic [CKPOS_W-1:0] ckpos_final;
   logic               out_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign rx        = req_word.rx_byte;
   assign pos_wide  = CKPOS_W'(byte_count_ff);

   always_comb begin
      length_upd = length_ff;
      if (byte_count_ff == COUNT_W'(3)) begin
         length_upd = {rx, length_ff[7:0]};
      end else if (byte_count_ff == COUNT_W'(4)) begin
         length_upd = {length_ff[LEN_W-1:8], rx};
      end
   end

   assign ckpos_upd = CKPOS_W'(length_upd) + CKPOS_OFFSET;

   always_comb begin
      active_in         = active_ff;
      byte_count_in     = byte_count_ff;
      tick_count_in     = tick_count_ff;
      header_matched_in = header_matched_ff;
      kind_in           = kind_ff;
      command_in        = command_ff;
      length_in         = length_ff;
      sum_in            = sum_ff;
      checksum_in       = checksum_ff;
      produce           = 1'b0;
      status            = STATUS_END;
      if (accept) begin
         unique case (req_word.req_type)
            REQ_ARM: begin
               active_in         = 1'b1;
               byte_count_in     = '0;
               tick_count_in     = '0;
               header_matched_in = 1'b0;
               kind_in           = '0;
               command_in        = '0;
               length_in         = '0;
               sum_in            = '0;
               checksum_in       = '0;
            end
            REQ_TICK: begin
               if (active_ff) begin
                  if (tick_count_ff != TICK_MAX) begin
                     tick_count_in = tick_count_ff + TICK_W'(1);
                  end
                  if (tick_count_in >= timeout_ff) begin
                     produce = 1'b1;
                     status  = STATUS_TIMEOUT;
                  end
               end
            end
            REQ_BYTE: begin
               if (active_ff) begin
                  if (byte_count_ff >= COUNT_W'(BUFFER_BYTES)) begin
                     produce = 1'b1;
                     status  = STATUS_OVERFLOW;
                  end else begin
                     if (byte_count_ff == '0) begin
                        header_matched_in = (rx == header_byte_ff);
                     end else begin
                        if (byte_count_ff == COUNT_W'(1)) kind_in = rx;
                        if (byte_count_ff == COUNT_W'(2)) command_in = rx;
                        length_in = length_upd;
                        if (pos_wide < ckpos_upd) begin
                           sum_in = sum_ff + rx;
                        end else if (pos_wide == ckpos_upd) begin
                           checksum_in = rx;
                        end
                     end
                     byte_count_in = byte_count_ff + COUNT_W'(1);
                     if (rx == end_byte_ff) begin
                        produce = 1'b1;
                        status  = STATUS_END;
                     end
                  end
               end
            end
            default: ;
         endcase
         if (produce) active_in = 1'b0;
      end
   end

   assign ckpos_final = CKPOS_W'(length_in) + CKPOS_OFFSET;

   always_comb begin
      result.status         = status;
      result.frame_ok       = (status == STATUS_END) && (byte_count_in > COUNT_W'(1))
                              && header_matched_in;
      result.checksum_ok    = (ckpos_final < CKPOS_W'(BUFFER_BYTES))
                              && (sum_in == checksum_in);
      result.command_code   = command_in;
      result.frame_kind     = kind_in;
      result.param_length   = length_in;
      result.bytes_received = RECV_W'(byte_count_in);
   end

   // output register with skid stage
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = produce;
            rsp_word_in  = result;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_word_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_ff    <= HEADER_BYTE_RESET;
         end_byte_ff       <= END_BYTE_RESET;
         timeout_ff        <= TIMEOUT_RESET;
         active_ff         <= 1'b0;
         byte_count_ff     <= '0;
         tick_count_ff     <= '0;
         header_matched_ff <= 1'b0;
         kind_ff           <= '0;
         command_ff        <= '0;
         length_ff         <= '0;
         sum_ff            <= '0;
         checksum_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_HEADER_BYTE:   header_byte_ff <= csr_wdata[7:0];
               CSR_END_BYTE:      end_byte_ff    <= csr_wdata[7:0];
               CSR_TIMEOUT_TICKS: timeout_ff     <= csr_wdata[TICK_W-1:0];
               default: ;
            endcase
         end
         active_ff         <= active_in;
         byte_count_ff     <= byte_count_in;
         tick_count_ff     <= tick_count_in;
         header_matched_ff <= header_matched_in;
         kind_ff           <= kind_in;
         command_ff        <= command_in;
         length_ff         <= length_in;
         sum_ff            <= sum_in;
         checksum_ff       <= checksum_in;
         rsp_valid_ff      <= rsp_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff  <= rsp_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule

[rtl/rfr_checker.sv]
// ----------------------------------------------------------------------------
// rfr_checker
// Port-level checks on the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module rfr_checker
   import rfr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_frame_ok_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.frame_ok |-> rsp_word.status == STATUS_END)
      else $error("frame ok without end byte");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_word.bytes_received) <= 32'(BUFFER_BYTES))
      else $error("byte count beyond buffer");

   a_checksum_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.checksum_ok
         |-> 32'(rsp_word.param_length) + 32'd5 < 32'(BUFFER_BYTES))
      else $error("checksum ok with position outside buffer");

endmodule

bind rfid_frame_receiver_checker_core rfr_checker u_rfr_checker (.*);

[sim/rfid_frame_receiver_checker_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rfid_frame_receiver_checker_core_tb
// Self-checking bench for the reader reply frame receiver. A scoreboard class
// tracks the open frame (count, length, running sum, checksum byte, ticks) for
// every accepted request word and queues the status word it must produce;
// each status word taken from the block is compared field by field. Stimulus
// is a short directed part followed by randomised frames (well formed, long,
// truncated, broken, noise) under several register settings, with bursty
// sending, patterned receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module rfid_frame_receiver_checker_core_tb;
   import rfr_pkg::*;

   localparam logic [1:0] REQ_SPARE   = 2'd3;
   localparam int         HOLD_CYCLES = 400;
   localparam int         IDLE_LIMIT  = 3000;
   localparam int         PHASE_WORDS = 310;

   class frame_status_tracker;
      logic [7:0]        header_value;
      logic [7:0]        end_value;
      logic [TICK_W-1:0] timeout_limit;
      bit                open;
      int unsigned       count;
      int unsigned       ticks;
      bit                header_hit;
      logic [7:0]        kind;
      logic [7:0]        command;
      int unsigned       length;
      logic [7:0]        sum;
      logic [7:0]        checksum;
      rsp_word_type      due_status[$];
      int                errors;

      function new();
         header_value  = HEADER_BYTE_RESET;
         end_value     = END_BYTE_RESET;
         timeout_limit = TIMEOUT_RESET;
         open          = 1'b0;
         errors        = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         count      = 0;
         ticks      = 0;
         header_hit = 1'b0;
         kind       = '0;
         command    = '0;
         length     = 0;
         sum        = '0;
         checksum   = '0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_HEADER_BYTE:   header_value  = data[7:0];
            CSR_END_BYTE:      end_value     = data[7:0];
            CSR_TIMEOUT_TICKS: timeout_limit = data[TICK_W-1:0];
            default: ;
         endcase
      endfunction

      function void close_frame(logic [1:0] status);
         rsp_word_type w;
         w.status         = status;
         w.frame_ok       = (status == STATUS_END) && (count > 1) && header_hit;
         w.checksum_ok    = (length + CKPOS_OFFSET < BUFFER_BYTES) && (sum == checksum);
         w.command_code   = command;
         w.frame_kind     = kind;
         w.param_length   = LEN_W'(length);
         w.bytes_received = RECV_W'(count);
         due_status.push_back(w);
         open = 1'b0;
      endfunction

      // returns 1 when the word changes the receiver state
      function bit take_request(req_word_type w);
         int unsigned pos;
         logic [7:0]  b;
         b = w.rx_byte;
         if (w.req_type == REQ_ARM) begin
            clear_frame();
            open = 1'b1;
            return 1'b1;
         end
         if (!open || (w.req_type != REQ_TICK && w.req_type != REQ_BYTE))
            return 1'b0;
         if (w.req_type == REQ_TICK) begin
            if (ticks < TICK_MAX)
               ticks++;
            if (ticks >= timeout_limit)
               close_frame(STATUS_TIMEOUT);
            return 1'b1;
         end
         pos = count;
         if (pos >= BUFFER_BYTES) begin
            close_frame(STATUS_OVERFLOW);
            return 1'b1;
         end
         if (pos == 0) begin
            header_hit = (b == header_value);
         end else begin
            if (pos == 1)
               kind = b;
            else if (pos == 2)
               command = b;
            else if (pos == 3)
               length = (int'(b) << 8) | (length & 'hFF);
            else if (pos == 4)
               length = (length & 'hFF00) | int'(b);
            if (pos < length + CKPOS_OFFSET)
               sum = sum + b;
            else if (pos == length + CKPOS_OFFSET)
               checksum = b;
         end
         count = pos + 1;
         if (b == end_value)
            close_frame(STATUS_END);
         return 1'b1;
      endfunction

      function string show(rsp_word_type w);
         return $sformatf("st=%0d fok=%0b cok=%0b cmd=%02h kind=%02h len=%04h cnt=%0d",
                          w.status, w.frame_ok, w.checksum_ok, w.command_code,
                          w.frame_kind, w.param_length, w.bytes_received);
      endfunction

      function void compare_status(rsp_word_type got);
         rsp_word_type want;
         if (due_status.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("status word with none due: %s", show(got));
            return;
         end
         want = due_status.pop_front();
         if (got.status !== want.status || got.frame_ok !== want.frame_ok ||
             got.checksum_ok !== want.checksum_ok ||
             got.command_code !== want.command_code ||
             got.frame_kind !== want.frame_kind ||
             got.param_length !== want.param_length ||
             got.bytes_received !== want.bytes_received) begin
            errors++;
            if (errors <= 10)
               $display("status word mismatch: expected %s, got %s", show(want), show(got));
         end
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_word_type           req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   frame_status_tracker tracker = new();

   bit hold_wanted = 1'b0;
   bit sending     = 1'b0;
   bit steady      = 1'b0;
   int burst_left  = 0;
   int effective   = 0;

   rfid_frame_receiver_checker_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.compare_status(rsp_word);
   end

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int mode;
      int span;
      int k;
      bit stall_next;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_wanted) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_wanted = 1'b0;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            for (k = 0; k < span && !hold_wanted; k++) begin
               case (mode)
                  0:       stall_next = 1'b0;
                  1:       stall_next = ($urandom_range(0, 3) == 0);
                  2:       stall_next = ($urandom_range(0, 3) != 0);
                  default: stall_next = k[0];
               endcase
               rsp_stall <= stall_next;
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [7:0] not_end();
      logic [7:0] v;
      v = 8'($urandom);
      while (v == tracker.end_value)
         v = 8'($urandom);
      return v;
   endfunction

   task automatic offer(input logic [1:0] kind, input logic [7:0] data);
      req_word_type w;
      w.req_type = kind;
      w.rx_byte  = data;
      req_valid <= 1'b1;
      req_word  <= w;
      sending = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (tracker.take_request(w))
         effective++;
      if (!steady) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 40);
            if ($urandom_range(0, 3) != 0) begin
               req_valid <= 1'b0;
               sending = 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
         end
      end
   endtask

   task automatic settle();
      if (sending) begin
         req_valid <= 1'b0;
         sending = 1'b0;
      end
      while (tracker.due_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_config(input logic [7:0] header_value, input logic [7:0] end_value,
                               input logic [TICK_W-1:0] timeout_limit);
      logic [CSR_INDEX_W-1:0] idx[3];
      logic [CSR_DATA_W-1:0]  val[3];
      idx = '{CSR_HEADER_BYTE, CSR_END_BYTE, CSR_TIMEOUT_TICKS};
      val = '{{8'h00, header_value}, {8'h00, end_value}, timeout_limit};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         tracker.write_register(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_frame();
      int         shape;
      int         len;
      int         n;
      int         k;
      logic [7:0] sum;
      logic [7:0] b;
      shape = $urandom_range(0, 99);
      if (shape < 60) begin
         offer(REQ_ARM, 8'($urandom));
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 58) : $urandom_range(0, 8);
         offer(REQ_BYTE, ($urandom_range(0, 7) == 0) ? 8'($urandom) : tracker.header_value);
         sum = 8'(len);
         b = not_end();
         sum = sum + b;
         offer(REQ_BYTE, b);
         b = not_end();
         sum = sum + b;
         offer(REQ_BYTE, b);
         offer(REQ_BYTE, 8'(len >> 8));
         offer(REQ_BYTE, 8'(len));
         for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 15) == 0)
               offer(REQ_TICK, 8'($urandom));
            b = not_end();
            sum = sum + b;
            offer(REQ_BYTE, b);
         end
         offer(REQ_BYTE, ($urandom_range(0, 7) == 0) ? 8'($urandom) : sum);
         offer(REQ_BYTE, tracker.end_value);
      end else if (shape < 70) begin
         // long frames: checksum past the buffer, full buffer, overflow
         offer(REQ_ARM, 8'($urandom));
         offer(REQ_BYTE, tracker.header_value);
         n = $urandom_range(40, 66);
         for (k = 0; k < n; k++)
            offer(REQ_BYTE, not_end());
         offer(REQ_BYTE, tracker.end_value);
      end else if (shape < 82) begin
         offer(REQ_ARM, 8'($urandom));
         n = $urandom_range(0, 6);
         for (k = 0; k < n; k++)
            offer(REQ_BYTE, not_end());
         n = tracker.timeout_limit;
         if (n > 64)
            n = $urandom_range(0, 5);
         else if (n == 0)
            n = 1;
         for (k = 0; k < n; k++)
            offer(REQ_TICK, 8'($urandom));
      end else if (shape < 90) begin
         offer(REQ_ARM, 8'($urandom));
         n = $urandom_range(1, 10);
         for (k = 0; k < n; k++)
            offer(REQ_BYTE, ($urandom_range(0, 9) < 3) ? tracker.end_value : 8'($urandom));
      end else begin
         n = $urandom_range(1, 6);
         for (k = 0; k < n; k++)
            offer(2'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      int target;
      int k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // nothing open yet: all ignored
      offer(REQ_BYTE, END_BYTE_RESET);
      offer(REQ_TICK, 8'h00);
      offer(REQ_SPARE, 8'hFF);
      // good frame, two parameter bytes
      offer(REQ_ARM, 8'hFF);
      offer(REQ_BYTE, HEADER_BYTE_RESET);
      offer(REQ_BYTE, 8'h01);
      offer(REQ_BYTE, 8'h22);
      offer(REQ_BYTE, 8'h00);
      offer(REQ_BYTE, 8'h02);
      offer(REQ_BYTE, 8'h00);
      offer(REQ_BYTE, 8'hFF);
      offer(REQ_BYTE, 8'h24);
      offer(REQ_BYTE, END_BYTE_RESET);
      // re-arm drops the open frame, then bad header and a spare request
      offer(REQ_ARM, 8'h00);
      offer(REQ_BYTE, HEADER_BYTE_RESET);
      offer(REQ_ARM, 8'h00);
      offer(REQ_BYTE, 8'h55);
      offer(REQ_SPARE, 8'h00);
      offer(REQ_BYTE, END_BYTE_RESET);
      // lone end byte
      offer(REQ_ARM, 8'h00);
      offer(REQ_BYTE, END_BYTE_RESET);
      settle();

      target = effective;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       apply_config(HEADER_BYTE_RESET, END_BYTE_RESET, TIMEOUT_RESET);
            1:       apply_config(8'h00, 8'hFF, 16'd1);
            2:       apply_config(8'hFF, 8'h00, 16'd0);
            3:       apply_config(8'($urandom), 8'($urandom), 16'($urandom_range(12, 40)));
            4:       apply_config(8'($urandom), 8'($urandom), TICK_MAX);
            default: apply_config(8'h7E, 8'h0D, 16'd25);
         endcase
         offer(REQ_ARM, 8'($urandom));
         offer(REQ_TICK, 8'($urandom));
         if (p == 0) begin
            hold_wanted = 1'b1;
            steady = 1'b1;
            for (k = 0; k < 20; k++) begin
               offer(REQ_ARM, 8'($urandom));
               offer(REQ_BYTE, tracker.end_value);
            end
            steady = 1'b0;
         end
         target += PHASE_WORDS;
         while (effective < target)
            random_frame();
         settle();
      end

      if (tracker.errors == 0 && tracker.due_status.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
